/* rtl/ppbc_pkg.sv */
// shared types, constants and a saturating helper function for the pid pitch balance controller
// used by the core, register file, sequencer and datapath modules; no dependencies
`default_nettype none
package ppbc_pkg;

  localparam int unsigned TERM_W = 21;
  localparam int unsigned PROD_W = 58;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic signed [TERM_W-1:0] TERM_MAX = 21'sd1048575;
  localparam logic signed [TERM_W-1:0] TERM_MIN = -21'sd1048576;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_PITCH   = 3'd0,
    REG_PROP_GAIN      = 3'd1,
    REG_INTEG_GAIN     = 3'd2,
    REG_DERIV_GAIN     = 3'd3,
    REG_MAX_COMMAND    = 3'd4,
    REG_INTEGRAL_LIMIT = 3'd5,
    REG_INVERT_OUTPUT  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] target_pitch;
    logic [23:0] proportional_gain;
    logic [23:0] integral_gain;
    logic [23:0] derivative_gain;
    logic [14:0] max_command;
    logic [30:0] integral_limit;
    logic        invert_output;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_ET,
    ST_MUL_P,
    ST_MUL_D,
    ST_MUL_IC,
    ST_MUL_IO,
    ST_COMMIT,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    MUL_ERR_TIME,
    MUL_PROP,
    MUL_DERIV,
    MUL_INT_CAND,
    MUL_INT_OLD
  } mul_sel_t;

  typedef struct packed {
    logic     capture;
    mul_sel_t mul_sel;
    logic     ld_cand;
    logic     ld_p;
    logic     ld_d;
    logic     ld_icand;
    logic     ld_iold;
    logic     commit;
    logic     ld_out;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  function automatic logic signed [TERM_W-1:0] sat_term(input logic signed [PROD_W-1:0] x);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = PROD_W'(TERM_MAX);
    lo = PROD_W'(TERM_MIN);
    if (x > hi) begin
      return TERM_MAX;
    end else if (x < lo) begin
      return TERM_MIN;
    end
    return x[TERM_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/pid_pitch_balance_controller_core.sv */
// top level of the pid pitch balance controller with conditional integration
// depends on ppbc_pkg, ppbc_cfg_regs, ppbc_ctrl and ppbc_dp
`default_nettype none
// Each request runs through these steps from acceptance to the next
// acceptance: one 33x25 multiplier is shared over five products (error
// times elapsed time, P, D, I on the candidate integral, I on the held
// integral), followed by a commit step and an output step. A request with
// attitude_valid low skips straight to the output step. The result
// sits in an output register, so a new request is taken while the previous
// result waits; the block stalls its input only while it is computing, or
// while a finished result cannot yet be handed over. Configuration writes are
// always accepted (cfg_ready is tied high) and should be made while idle.
module pid_pitch_balance_controller_core import ppbc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_attitude_valid,
  input  wire logic [15:0]           in_pitch_angle,
  input  wire logic [15:0]           in_pitch_rate,
  input  wire logic [15:0]           in_pitch_offset,
  input  wire logic [15:0]           in_elapsed_time,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [15:0]                out_motor_command,
  output logic                       out_saturated,
  output logic [20:0]                out_raw_command,
  output logic [16:0]                out_requested_pitch,
  output logic [17:0]                out_pitch_error,
  output logic [20:0]                out_proportional_term,
  output logic [20:0]                out_integral_term,
  output logic [20:0]                out_derivative_term
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  ppbc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  ppbc_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_attitude_valid (in_attitude_valid),
    .in_stall          (in_stall),
    .status            (status),
    .cmd               (cmd)
  );

  ppbc_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg                   (cfg),
    .cmd                   (cmd),
    .status                (status),
    .in_attitude_valid     (in_attitude_valid),
    .in_pitch_angle        (in_pitch_angle),
    .in_pitch_rate         (in_pitch_rate),
    .in_pitch_offset       (in_pitch_offset),
    .in_elapsed_time       (in_elapsed_time),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_motor_command     (out_motor_command),
    .out_saturated         (out_saturated),
    .out_raw_command       (out_raw_command),
    .out_requested_pitch   (out_requested_pitch),
    .out_pitch_error       (out_pitch_error),
    .out_proportional_term (out_proportional_term),
    .out_integral_term     (out_integral_term),
    .out_derivative_term   (out_derivative_term)
  );

endmodule
`default_nettype wire

/* rtl/ppbc_cfg_regs.sv */
// configuration register file for the pid pitch balance controller
// depends on ppbc_pkg for the register index codes and cfg_t
`default_nettype none
module ppbc_cfg_regs import ppbc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_TARGET_PITCH:   cfg_nxt.target_pitch      = wr_data[15:0];
        REG_PROP_GAIN:      cfg_nxt.proportional_gain = wr_data[23:0];
        REG_INTEG_GAIN:     cfg_nxt.integral_gain     = wr_data[23:0];
        REG_DERIV_GAIN:     cfg_nxt.derivative_gain   = wr_data[23:0];
        REG_MAX_COMMAND:    cfg_nxt.max_command       = wr_data[14:0];
        REG_INTEGRAL_LIMIT: cfg_nxt.integral_limit    = wr_data[30:0];
        REG_INVERT_OUTPUT:  cfg_nxt.invert_output     = wr_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_pitch      <= '0;
      cfg_r.proportional_gain <= '0;
      cfg_r.integral_gain     <= '0;
      cfg_r.derivative_gain   <= '0;
      cfg_r.max_command       <= '1;
      cfg_r.integral_limit    <= '1;
      cfg_r.invert_output     <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

/* rtl/ppbc_ctrl.sv */
// sequencer for the pid pitch balance controller: steps the shared multiplier
// depends on ppbc_pkg for state_t, cmd_t and status_t
`default_nettype none
module ppbc_ctrl import ppbc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  input  wire logic    in_attitude_valid,
  output logic         in_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_attitude_valid ? ST_MUL_ET : ST_OUT;
        end
      end
      ST_MUL_ET: state_nxt = ST_MUL_P;
      ST_MUL_P:  state_nxt = ST_MUL_D;
      ST_MUL_D:  state_nxt = ST_MUL_IC;
      ST_MUL_IC: state_nxt = ST_MUL_IO;
      ST_MUL_IO: state_nxt = ST_COMMIT;
      ST_COMMIT: state_nxt = ST_OUT;
      ST_OUT: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.mul_sel = MUL_ERR_TIME;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_MUL_ET: cmd.mul_sel = MUL_ERR_TIME;
      ST_MUL_P: begin
        cmd.mul_sel = MUL_PROP;
        cmd.ld_cand = 1'b1;
      end
      ST_MUL_D: begin
        cmd.mul_sel = MUL_DERIV;
        cmd.ld_p    = 1'b1;
      end
      ST_MUL_IC: begin
        cmd.mul_sel = MUL_INT_CAND;
        cmd.ld_d    = 1'b1;
      end
      ST_MUL_IO: begin
        cmd.mul_sel  = MUL_INT_OLD;
        cmd.ld_icand = 1'b1;
      end
      ST_COMMIT: begin
        cmd.ld_iold = 1'b1;
        cmd.commit  = 1'b1;
      end
      ST_OUT: cmd.ld_out = status.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/ppbc_dp.sv */
// datapath for the pid pitch balance controller: shared multiplier, integral
// state, term registers and the output register; depends on ppbc_pkg
`default_nettype none
module ppbc_dp import ppbc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire cmd_t        cmd,
  output status_t          status,
  input  wire logic        in_attitude_valid,
  input  wire logic [15:0] in_pitch_angle,
  input  wire logic [15:0] in_pitch_rate,
  input  wire logic [15:0] in_pitch_offset,
  input  wire logic [15:0] in_elapsed_time,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_motor_command,
  output logic             out_saturated,
  output logic [20:0]      out_raw_command,
  output logic [16:0]      out_requested_pitch,
  output logic [17:0]      out_pitch_error,
  output logic [20:0]      out_proportional_term,
  output logic [20:0]      out_integral_term,
  output logic [20:0]      out_derivative_term
);

  // request capture
  logic               ok_r;
  logic signed [16:0] req_r;
  logic signed [17:0] err_r;
  logic [15:0]        rate_r;
  logic [15:0]        dt_r;
  logic signed [16:0] req_nxt;
  logic signed [17:0] err_nxt;

  assign req_nxt = $signed({cfg.target_pitch[15], cfg.target_pitch})
                 + $signed({in_pitch_offset[15], in_pitch_offset});
  assign err_nxt = $signed({in_pitch_angle[15], in_pitch_angle[15], in_pitch_angle})
                 - $signed({req_nxt[16], req_nxt});

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ok_r   <= in_attitude_valid;
      req_r  <= req_nxt;
      err_r  <= err_nxt;
      rate_r <= in_pitch_rate;
      dt_r   <= in_elapsed_time;
    end
  end

  // shared multiplier
  logic signed [32:0]       mul_a;
  logic signed [24:0]       mul_b;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [31:0]       integ_r;
  logic signed [31:0]       cand_r;

  always_comb begin
    mul_a = 33'(err_r);
    mul_b = $signed({9'd0, dt_r});
    case (cmd.mul_sel)
      MUL_ERR_TIME: begin
        mul_a = 33'(err_r);
        mul_b = $signed({9'd0, dt_r});
      end
      MUL_PROP: begin
        mul_a = 33'(err_r);
        mul_b = $signed({1'b0, cfg.proportional_gain});
      end
      MUL_DERIV: begin
        mul_a = 33'($signed(rate_r));
        mul_b = $signed({1'b0, cfg.derivative_gain});
      end
      MUL_INT_CAND: begin
        mul_a = 33'(cand_r);
        mul_b = $signed({1'b0, cfg.integral_gain});
      end
      MUL_INT_OLD: begin
        mul_a = 33'(integ_r);
        mul_b = $signed({1'b0, cfg.integral_gain});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // candidate integral, clamped
  logic signed [PROD_W-1:0] et_sh;
  logic signed [33:0]       cand_sum;
  logic signed [33:0]       lim_pos;
  logic signed [33:0]       lim_neg;
  logic signed [31:0]       cand_nxt;

  assign et_sh    = prod_r >>> 20;
  assign cand_sum = 34'(integ_r) + et_sh[33:0];
  assign lim_pos  = $signed({3'd0, cfg.integral_limit});
  assign lim_neg  = -lim_pos;

  always_comb begin
    if (cand_sum > lim_pos) begin
      cand_nxt = lim_pos[31:0];
    end else if (cand_sum < lim_neg) begin
      cand_nxt = lim_neg[31:0];
    end else begin
      cand_nxt = cand_sum[31:0];
    end
  end

  // term registers
  logic signed [TERM_W-1:0] p_r;
  logic signed [TERM_W-1:0] d_r;
  logic signed [TERM_W-1:0] icand_r;
  logic signed [TERM_W-1:0] iold_r;
  logic                     commit_r;
  logic signed [TERM_W-1:0] sh9_sat;
  logic signed [TERM_W-1:0] sh5_sat;

  assign sh9_sat = sat_term(prod_r >>> 9);
  assign sh5_sat = sat_term(prod_r >>> 5);

  // anti-windup: hold the integral when the candidate command pushes further out
  logic signed [22:0] ccmd;
  logic signed [22:0] maxc23;
  logic               err_pos;
  logic               err_neg;
  logic               commit_ok;

  assign ccmd    = 23'(p_r) + 23'(icand_r) + 23'(d_r);
  assign maxc23  = $signed({8'd0, cfg.max_command});
  assign err_neg = err_r[17];
  assign err_pos = !err_r[17] && (err_r != '0);
  assign commit_ok = !((ccmd > maxc23 && err_pos) || (ccmd < -maxc23 && err_neg));

  always_ff @(posedge clk) begin
    if (cmd.ld_cand) begin
      cand_r <= cand_nxt;
    end
    if (cmd.ld_p) begin
      p_r <= sh9_sat;
    end
    if (cmd.ld_d) begin
      d_r <= sh5_sat;
    end
    if (cmd.ld_icand) begin
      icand_r <= sh9_sat;
    end
    if (cmd.ld_iold) begin
      iold_r <= sh9_sat;
    end
    if (cmd.commit) begin
      commit_r <= commit_ok;
    end
  end

  logic signed [31:0] integ_nxt;

  always_comb begin
    integ_nxt = integ_r;
    if (cmd.commit && commit_ok) begin
      integ_nxt = cand_r;
    end
  end

  // final command, inversion and limit
  logic signed [TERM_W-1:0] ic;
  logic signed [22:0]       sum;
  logic signed [23:0]       sum_inv;
  logic signed [TERM_W-1:0] raw;
  logic signed [21:0]       raw22;
  logic signed [21:0]       maxc22;
  logic                     sat_hi;
  logic                     sat_lo;
  logic signed [21:0]       mc;

  assign ic      = commit_r ? icand_r : iold_r;
  assign sum     = 23'(p_r) + 23'(ic) + 23'(d_r);
  assign sum_inv = cfg.invert_output ? -24'(sum) : 24'(sum);
  assign raw     = sat_term(PROD_W'(sum_inv));
  assign raw22   = 22'(raw);
  assign maxc22  = $signed({7'd0, cfg.max_command});
  assign sat_hi  = raw22 > maxc22;
  assign sat_lo  = raw22 < -maxc22;

  always_comb begin
    if (sat_hi) begin
      mc = maxc22;
    end else if (sat_lo) begin
      mc = -maxc22;
    end else begin
      mc = raw22;
    end
  end

  // output register
  logic out_valid_r;
  logic out_valid_nxt;

  assign status.out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.ld_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      integ_r     <= integ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  logic [15:0] motor_r;
  logic        sat_r;
  logic [20:0] raw_r;
  logic [16:0] req_out_r;
  logic [17:0] err_out_r;
  logic [20:0] p_out_r;
  logic [20:0] i_out_r;
  logic [20:0] d_out_r;

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      req_out_r <= req_r;
      if (ok_r) begin
        motor_r   <= mc[15:0];
        sat_r     <= sat_hi || sat_lo;
        raw_r     <= raw;
        err_out_r <= err_r;
        p_out_r   <= p_r;
        i_out_r   <= ic;
        d_out_r   <= d_r;
      end else begin
        motor_r   <= '0;
        sat_r     <= 1'b0;
        raw_r     <= '0;
        err_out_r <= '0;
        p_out_r   <= '0;
        i_out_r   <= '0;
        d_out_r   <= '0;
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_motor_command     = motor_r;
  assign out_saturated         = sat_r;
  assign out_raw_command       = raw_r;
  assign out_requested_pitch   = req_out_r;
  assign out_pitch_error       = err_out_r;
  assign out_proportional_term = p_out_r;
  assign out_integral_term     = i_out_r;
  assign out_derivative_term   = d_out_r;

endmodule
`default_nettype wire

/* rtl/ppbc_checker.sv */
// port-level checks for the pid pitch balance controller, bound to the top level
// depends on pid_pitch_balance_controller_core for the bind target
`default_nettype none
module ppbc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] out_motor_command,
  input wire logic        out_saturated,
  input wire logic [20:0] out_raw_command
);

  // no result straight after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while busy");

  // an unlimited command passes straight through
  a_unsat_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_saturated |->
      out_motor_command == out_raw_command[15:0]
      && (out_raw_command[20:15] == 6'h00 || out_raw_command[20:15] == 6'h3f))
    else $error("unsaturated command differs from raw command");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_raw_command))
    else $error("stalled result changed");

endmodule

bind pid_pitch_balance_controller_core ppbc_checker u_ppbc_checker (.*);
`default_nettype wire
